// ===== hdl/stsfv_pkg.sv =====
// ---------------------------------------------------------------------------
// stsfv_pkg: shared constants, types and arithmetic helpers
// Fixed point formats, status codes and register indexes of the slip face block.
// ---------------------------------------------------------------------------
package stsfv_pkg;

  localparam int FracBits   = 16;
  localparam int NormFrac   = 15;
  localparam int QuoBits    = 32;        // quotient magnitude bits, cap 2^31+1
  localparam int DivNumW    = 63;        // numerator width of the long division
  localparam int DivDenW    = 62;        // divisor width (31 x 31 product)
  localparam int DivSteps   = DivNumW + FracBits;
  localparam int DivStages  = 20;
  localparam int DivPerStg  = (DivSteps + DivStages - 1) / DivStages;

  localparam logic [31:0] MagCap = 32'h8000_0001;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_SLOPE   = 2'd0,
    REG_DENSITY = 2'd1,
    REG_GRAD_EN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic div0;
    logic ovf;
  } flags_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [32:0] sat32(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sd2147483647) r = {1'b1, 32'h7fff_ffff};
    else if (x < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  // signed value from sign and magnitude with saturation, bit 32 = overflow
  function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] m);
    logic [32:0] r;
    if (neg) begin
      if (m > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(-m)};
    end else begin
      if (m > 64'h7fff_ffff) r = {1'b1, 32'h7fff_ffff};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

  // truncating shift toward zero
  function automatic logic signed [65:0] trunc_shr(input logic signed [65:0] x);
    logic [65:0] m;
    m = x[65] ? 66'(-x) : 66'(x);
    m = m >> NormFrac;
    return x[65] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== hdl/stsfv_div.sv =====
// ---------------------------------------------------------------------------
// stsfv_div: pipelined restoring long division
// Three lanes of floor(a * 2^FracBits / d) capped at MagCap, several bits per stage.
// ---------------------------------------------------------------------------
module stsfv_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic [2:0][stsfv_pkg::DivNumW-1:0]   num_i,
  input  logic [stsfv_pkg::DivDenW-1:0]        den_i,
  input  logic [2:0]                           neg_i,
  output logic                                 vld_o,
  output logic [2:0][31:0]                     quo_o,
  output logic [2:0]                           neg_o,
  output logic                                 div0_o
);

  localparam int S = stsfv_pkg::DivStages;
  localparam int P = stsfv_pkg::DivPerStg;
  localparam int T = stsfv_pkg::DivSteps;
  localparam int NW = stsfv_pkg::DivNumW;
  localparam int DW = stsfv_pkg::DivDenW;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
    logic [2:0][DW:0]   rem;
    logic [2:0][33:0]   quo;     // bit 33 sticky cap
    logic [2:0]         nz;      // numerator nonzero
    logic [2:0]         neg;
    logic [DW-1:0]      den;
  } dstg_t;

  dstg_t       stg_q [S+1];
  logic [S:0]  vld_q;
  dstg_t       stg_d [S];
  dstg_t       stg_in;

  always_comb begin
    stg_in = '0;
    for (int l = 0; l < 3; l++) begin
      stg_in.num[l] = num_i[l];
      stg_in.nz[l]  = |num_i[l];
    end
    stg_in.neg = neg_i;
    stg_in.den = den_i;
  end

  assign stg_d[0] = stg_in;

  // each stage runs up to P dependent restoring steps
  for (genvar s = 0; s < S; s++) begin : g_stg
    dstg_t nx;
    always_comb begin
      logic [DW+1:0] t;
      logic          bitin;
      nx = stg_q[s];
      for (int k = 0; k < P; k++) begin
        if (s * P + k < T) begin
          for (int l = 0; l < 3; l++) begin
            bitin = nx.num[l][NW-1];
            nx.num[l] = {nx.num[l][NW-2:0], 1'b0};
            t = {nx.rem[l], bitin};
            nx.quo[l][32:0] = {nx.quo[l][31:0], 1'b0};
            if (t >= {2'b0, nx.den}) begin
              t = t - {2'b0, nx.den};
              nx.quo[l][0] = 1'b1;
            end
            nx.rem[l] = t[DW:0];
            if (nx.quo[l][32:0] >= {1'b0, stsfv_pkg::MagCap}) begin
              nx.quo[l][33] = 1'b1;
              nx.quo[l][32:0] = {1'b0, stsfv_pkg::MagCap};
            end
          end
        end
      end
    end
    if (s + 1 < S) begin : g_next
      assign stg_d[s+1] = nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[S-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < S; s++) stg_q[s] <= stg_d[s];
      stg_q[S] <= g_stg[S-1].nx;
    end
  end

  logic zero_den;
  assign zero_den = (stg_q[S].den == '0);

  always_comb begin
    div0_o = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (zero_den) begin
        // zero numerator gives zero, else saturate
        if (stg_q[S].nz[l]) begin
          quo_o[l] = stsfv_pkg::MagCap;
          div0_o = 1'b1;
        end else begin
          quo_o[l] = '0;
        end
      end else if (stg_q[S].quo[l][33]) begin
        quo_o[l] = stsfv_pkg::MagCap;
      end else begin
        quo_o[l] = stg_q[S].quo[l][31:0];
      end
    end
  end

  assign vld_o = vld_q[S];
  assign neg_o = stg_q[S].neg;

endmodule

// ===== hdl/surface_tension_slip_face_value_top.sv =====
// ---------------------------------------------------------------------------
// surface_tension_slip_face_value_top
// Marangoni slip face value: per-face tangential velocity and normal gradient.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake
//  in       | input     | in_valid_i / in_stall_o
//  out      | output    | out_valid_o / out_stall_i
//  cfg      | input     | cfg_valid_i / cfg_ready_o (always ready)
//
// one face per cycle while the output is not stalled; a face reaches the outputs
// through five front stages, two 21-stage long dividers with one stage between
// them, and seven back stages ending in the output register.
// the whole pipeline advances only while the output register is free,
// so a stall holds every stage; reset clears all valid bits.
// ---------------------------------------------------------------------------
module surface_tension_slip_face_value_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] normal_x_i,
  input  logic [15:0] normal_y_i,
  input  logic [15:0] normal_z_i,
  input  logic [31:0] temp_grad_x_i,
  input  logic [31:0] temp_grad_y_i,
  input  logic [31:0] temp_grad_z_i,
  input  logic [30:0] eff_viscosity_i,
  input  logic [31:0] cell_vel_x_i,
  input  logic [31:0] cell_vel_y_i,
  input  logic [31:0] cell_vel_z_i,
  input  logic [30:0] inv_distance_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] face_vel_x_o,
  output logic [31:0] face_vel_y_o,
  output logic [31:0] face_vel_z_o,
  output logic [31:0] normal_grad_x_o,
  output logic [31:0] normal_grad_y_o,
  output logic [31:0] normal_grad_z_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NW = stsfv_pkg::DivNumW;
  localparam int DW = stsfv_pkg::DivDenW;

  logic               en;
  logic signed [31:0] slope_q;
  logic [30:0]        dens_q;
  logic               gen_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= '0;
      dens_q  <= 31'(1 << stsfv_pkg::FracBits);
      gen_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stsfv_pkg::REG_SLOPE:   slope_q <= cfg_data_i;
        stsfv_pkg::REG_DENSITY: dens_q  <= cfg_data_i[30:0];
        stsfv_pkg::REG_GRAD_EN: gen_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // common per-face context carried along the pipeline
  typedef struct packed {
    logic [2:0][15:0] n;
    logic [2:0][31:0] c;
    logic [30:0]      dl;
    logic             pass;
    stsfv_pkg::flags_t fl;
  } ctx_t;

  // ---- stage 1: n.g products
  logic               v1_q;
  ctx_t               x1_q;
  logic [2:0][31:0]   g1_q;
  logic [30:0]        nu1_q;
  logic signed [2:0][47:0] p1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q.n    <= {normal_z_i, normal_y_i, normal_x_i};
      x1_q.c    <= {cell_vel_z_i, cell_vel_y_i, cell_vel_x_i};
      x1_q.dl   <= inv_distance_i;
      x1_q.pass <= !gen_q;
      x1_q.fl   <= '0;
      g1_q      <= {temp_grad_z_i, temp_grad_y_i, temp_grad_x_i};
      nu1_q     <= eff_viscosity_i;
      p1_q[0]   <= $signed(normal_x_i) * $signed(temp_grad_x_i);
      p1_q[1]   <= $signed(normal_y_i) * $signed(temp_grad_y_i);
      p1_q[2]   <= $signed(normal_z_i) * $signed(temp_grad_z_i);
    end
  end

  // ---- stage 2: dot reduced, density*nu
  logic v2_q; ctx_t x2_q; logic [2:0][31:0] g2_q;
  logic signed [65:0] dq2_q; logic [DW-1:0] den2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q   <= x1_q;
      g2_q   <= g1_q;
      dq2_q  <= stsfv_pkg::trunc_shr(66'($signed(p1_q[0])) + 66'($signed(p1_q[1]))
                                     + 66'($signed(p1_q[2])));
      den2_q <= DW'(dens_q) * DW'(nu1_q);
    end
  end

  // ---- stage 3: n_i * dq
  logic v3_q; ctx_t x3_q; logic [2:0][31:0] g3_q; logic [DW-1:0] den3_q;
  logic signed [2:0][65:0] nd3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_q   <= x2_q;
      g3_q   <= g2_q;
      den3_q <= den2_q;
      // reduced dot fits in 34 signed bits
      for (int i = 0; i < 3; i++) begin
        nd3_q[i] <= stsfv_pkg::trunc_shr(66'($signed(x2_q.n[i]) * $signed(dq2_q[34:0])));
      end
    end
  end

  // ---- stage 4: gp saturated
  logic v4_q; ctx_t x4_q; logic [2:0][31:0] gp4_q; logic [DW-1:0] den4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    logic [32:0] s;
    ctx_t        x;
    if (en) begin
      x      = x3_q;
      den4_q <= den3_q;
      for (int i = 0; i < 3; i++) begin
        s = stsfv_pkg::sat32(66'($signed(g3_q[i])) - nd3_q[i]);
        gp4_q[i] <= s[31:0];
        if (s[32]) x.fl.ovf = 1'b1;
      end
      x4_q <= x;
    end
  end

  // ---- stage 5: slope * gp magnitudes
  logic v5_q; ctx_t x5_q; logic [DW-1:0] den5_q;
  logic [2:0][NW-1:0] a5_q; logic [2:0] neg5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    logic [31:0] ms, mg;
    if (en) begin
      x5_q   <= x4_q;
      den5_q <= den4_q;
      ms = slope_q[31] ? 32'(-slope_q) : slope_q;
      for (int i = 0; i < 3; i++) begin
        mg = gp4_q[i][31] ? 32'(-gp4_q[i]) : gp4_q[i];
        a5_q[i]   <= NW'(ms) * NW'(mg);
        neg5_q[i] <= slope_q[31] != gp4_q[i][31];
      end
    end
  end

  // ---- divider 1 with context delay
  localparam int DL = stsfv_pkg::DivStages + 1;
  ctx_t xd1_q [DL];
  logic vd1; logic [2:0][31:0] q1; logic [2:0] qn1; logic z1;
  stsfv_div u_div_tau (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v5_q), .num_i(a5_q), .den_i(den5_q),
    .neg_i(neg5_q), .vld_o(vd1), .quo_o(q1), .neg_o(qn1), .div0_o(z1)
  );
  always_ff @(posedge clk_i) begin
    if (en) begin
      xd1_q[0] <= x5_q;
      for (int k = 1; k < DL; k++) xd1_q[k] <= xd1_q[k-1];
    end
  end

  // ---- stage 6: tau signed, magnitude for second division
  logic v6_q; ctx_t x6_q; logic [2:0][NW-1:0] a6_q; logic [2:0] neg6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= vd1;
  end
  always_ff @(posedge clk_i) begin
    logic [32:0] t;
    logic [31:0] m;
    ctx_t        x;
    if (en) begin
      x = xd1_q[DL-1];
      for (int i = 0; i < 3; i++) begin
        t = stsfv_pkg::from_mag(qn1[i], 64'(q1[i]));
        if (t[32]) x.fl.ovf = 1'b1;
        m = t[31] ? 32'(-t[31:0]) : t[31:0];
        a6_q[i]   <= NW'(m);
        neg6_q[i] <= t[31];
      end
      if (z1) x.fl.div0 = 1'b1;
      x6_q <= x;
    end
  end

  ctx_t xd2_q [DL];
  logic vd2; logic [2:0][31:0] q2; logic [2:0] qn2; logic z2;
  stsfv_div u_div_step (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v6_q), .num_i(a6_q),
    .den_i(DW'(x6_q.dl)), .neg_i(neg6_q), .vld_o(vd2), .quo_o(q2), .neg_o(qn2),
    .div0_o(z2)
  );
  always_ff @(posedge clk_i) begin
    if (en) begin
      xd2_q[0] <= x6_q;
      for (int k = 1; k < DL; k++) xd2_q[k] <= xd2_q[k-1];
    end
  end

  // ---- stage 7: w = c + step
  logic v7_q; ctx_t x7_q; logic [2:0][31:0] w7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= vd2;
  end
  always_ff @(posedge clk_i) begin
    logic [32:0] t, s;
    logic        o;
    ctx_t        x;
    if (en) begin
      x = xd2_q[DL-1];
      o = x.fl.ovf;
      for (int i = 0; i < 3; i++) begin
        t = stsfv_pkg::from_mag(qn2[i], 64'(q2[i]));
        s = stsfv_pkg::sat32(66'($signed(x.c[i])) + 66'($signed(t[31:0])));
        o = o | t[32] | s[32];
        w7_q[i] <= s[31:0];
      end
      x.fl.ovf  = o;
      x.fl.div0 = x.fl.div0 | z2;
      x7_q <= x;
    end
  end

  // ---- stage 8: n.w products
  logic v8_q; ctx_t x8_q; logic [2:0][31:0] w8_q; logic signed [2:0][47:0] p8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x8_q <= x7_q;
      w8_q <= w7_q;
      for (int i = 0; i < 3; i++) p8_q[i] <= $signed(x7_q.n[i]) * $signed(w7_q[i]);
    end
  end

  // ---- stage 9: dot reduced
  logic v9_q; ctx_t x9_q; logic [2:0][31:0] w9_q; logic signed [65:0] dq9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (en) v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x9_q  <= x8_q;
      w9_q  <= w8_q;
      dq9_q <= stsfv_pkg::trunc_shr(66'($signed(p8_q[0])) + 66'($signed(p8_q[1]))
                                    + 66'($signed(p8_q[2])));
    end
  end

  // ---- stage 10: n_i * dq
  logic v10_q; ctx_t x10_q; logic [2:0][31:0] w10_q; logic signed [2:0][65:0] nd10_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else if (en) v10_q <= v9_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x10_q <= x9_q;
      w10_q <= w9_q;
      for (int i = 0; i < 3; i++) begin
        nd10_q[i] <= stsfv_pkg::trunc_shr(66'($signed(x9_q.n[i]) * $signed(dq9_q[34:0])));
      end
    end
  end

  // ---- stage 11: value and diff magnitude
  logic v11_q; ctx_t x11_q; logic [2:0][31:0] val11_q;
  logic [2:0][32:0] dm11_q; logic [2:0] dn11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else if (en) v11_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    logic [32:0] s;
    logic signed [33:0] df;
    logic o;
    ctx_t x;
    if (en) begin
      x = x10_q;
      o = x.fl.ovf;
      for (int i = 0; i < 3; i++) begin
        s = stsfv_pkg::sat32(66'($signed(w10_q[i])) - nd10_q[i]);
        o = o | s[32];
        val11_q[i] <= s[31:0];
        df = 34'($signed(s[31:0])) - 34'($signed(x10_q.c[i]));
        dn11_q[i] <= df[33];
        dm11_q[i] <= df[33] ? 33'(-df) : df[32:0];
      end
      x.fl.ovf = o;
      x11_q <= x;
    end
  end

  // ---- stage 12: normal gradient product
  logic v12_q; ctx_t x12_q; logic [2:0][31:0] val12_q;
  logic [2:0][63:0] m12_q; logic [2:0] dn12_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v12_q <= 1'b0;
    else if (en) v12_q <= v11_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x12_q   <= x11_q;
      val12_q <= val11_q;
      dn12_q  <= dn11_q;
      for (int i = 0; i < 3; i++) begin
        m12_q[i] <= (64'(dm11_q[i]) * 64'(x11_q.dl)) >> stsfv_pkg::FracBits;
      end
    end
  end

  // ---- output register
  logic vo_q;
  logic [2:0][31:0] fv_q, ng_q; logic [1:0] st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= v12_q;
  end
  always_ff @(posedge clk_i) begin
    logic [32:0] t;
    logic o;
    if (en) begin
      o = x12_q.fl.ovf;
      for (int i = 0; i < 3; i++) begin
        t = stsfv_pkg::from_mag(dn12_q[i], m12_q[i]);
        o = o | t[32];
        if (x12_q.pass) begin
          fv_q[i] <= x12_q.c[i];
          ng_q[i] <= '0;
        end else begin
          fv_q[i] <= val12_q[i];
          ng_q[i] <= t[31:0];
        end
      end
      if (x12_q.pass) st_q <= stsfv_pkg::ST_OK;
      else if (x12_q.fl.div0) st_q <= stsfv_pkg::ST_DIV0;
      else if (o) st_q <= stsfv_pkg::ST_OVF;
      else st_q <= stsfv_pkg::ST_OK;
    end
  end

  assign out_valid_o     = vo_q;
  assign face_vel_x_o    = fv_q[0];
  assign face_vel_y_o    = fv_q[1];
  assign face_vel_z_o    = fv_q[2];
  assign normal_grad_x_o = ng_q[0];
  assign normal_grad_y_o = ng_q[1];
  assign normal_grad_z_o = ng_q[2];
  assign status_o        = st_q;

endmodule
